FILE: hw/rtl/nts_ke_request_validator_assert.svh
// Assertion macros shared by the NTS-KE request validator RTL.
`ifndef NTS_KE_REQUEST_VALIDATOR_ASSERT_SVH
`define NTS_KE_REQUEST_VALIDATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NKV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nts_ke validator assertion failed");

// Next-cycle implication, disabled during reset.
`define NKV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nts_ke validator assertion failed");

`endif

FILE: hw/rtl/nkv_pkg.sv
// Package: record types, flag positions and codes of the NTS-KE request validator.
package nkv_pkg;

    localparam int TYPE_W = 15;
    localparam int LEN_W  = 16;
    localparam int ID_W   = 16;
    localparam int CFG_IDX_W = 8;

    typedef enum logic [TYPE_W-1:0] {
        T_EOM      = 15'h0000,
        T_NEXTPROT = 15'h0001,
        T_ERROR    = 15'h0002,
        T_WARNING  = 15'h0003,
        T_AEAD     = 15'h0004,
        T_SERVER   = 15'h0006,
        T_PORT     = 15'h0007
    } rec_type_t;

    // seen flag bit positions
    localparam int SEEN_PROT  = 0;
    localparam int SEEN_AEAD  = 1;
    localparam int SEEN_END   = 2;
    localparam int OFFER_PROT = 3;
    localparam int OFFER_AEAD = 4;
    localparam int SEEN_W     = 5;

    localparam logic CODE_UNREC_CRIT = 1'b0;
    localparam logic CODE_BAD_REQ    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_REQ_PROT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REQ_AEAD = 8'd1;

    localparam logic [ID_W-1:0] REQ_PROT_RESET = 16'h0000;
    localparam logic [ID_W-1:0] REQ_AEAD_RESET = 16'h000F;

endpackage

FILE: hw/rtl/nts_ke_request_validator.sv
// NTS-KE client request validator: record parser, rule checks and verdict.
//
// Takes a client request one byte per transaction on s_axis (tlast marks the
// final byte) and splits it into records: a 4-byte big-endian header (critical
// bit, 15-bit type, 16-bit body length) and the body. End of message, next
// protocol, AEAD, error, warning, server and port records are checked as soon
// as their header is complete; protocol and AEAD lists are scanned in 16-bit
// words against the two configured identifiers. The first error is kept. The
// verdict appears on m_axis in the cycle after the byte with tlast is taken; no
// result is given for other bytes. Rate: one byte per clock, sustained; every
// byte updates the parser state as it is taken, so there is no bubble between
// requests. The input stalls only while a verdict sits in the output register
// untaken. Configuration (index 0: required protocol id, index 1: required
// AEAD id) is accepted in any cycle and should be written between requests.
module nts_ke_request_validator
    import nkv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
    input  logic                 s_axis_tlast,   // last_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [0] accepted, [1] reject_code, [7:2] zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ID_W-1:0]      cfg_data
);

    // configuration
    logic [ID_W-1:0] req_prot_reg, req_aead_reg;

    // parser state
    logic [1:0]        hdr_idx_reg,  hdr_idx_next;
    logic              in_body_reg,  in_body_next;
    logic [TYPE_W-1:0] rec_type_reg, rec_type_next;
    logic              crit_reg,     crit_next;
    logic [LEN_W-1:0]  body_rem_reg, body_rem_next;
    logic [8:0]        hold_reg,     hold_next;      // bit 8: high byte held
    logic [SEEN_W-1:0] seen_reg,     seen_next;
    logic              pend_reg,     pend_next;      // unknown critical body
    logic              err_reg,      err_next;
    logic              code_reg,     code_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_data_reg,  out_data_next;

    logic              s_fire, m_fire;
    logic [7:0]        b;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  rem_dec;
    logic [ID_W-1:0]   word;
    logic              bad;
    logic              verdict_acc;
    logic              verdict_code;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = out_valid_reg && m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

    assign b       = s_axis_tdata;
    assign len     = {body_rem_reg[LEN_W-1:8], b};
    assign rem_dec = body_rem_reg - 16'd1;
    assign word    = {hold_reg[7:0], b};

    always_comb
    begin
        hdr_idx_next  = hdr_idx_reg;
        in_body_next  = in_body_reg;
        rec_type_next = rec_type_reg;
        crit_next     = crit_reg;
        body_rem_next = body_rem_reg;
        hold_next     = hold_reg;
        seen_next     = seen_reg;
        pend_next     = pend_reg;
        err_next      = err_reg;
        code_next     = code_reg;
        bad           = 1'b0;

        if (s_fire && !err_reg) begin
            if (in_body_reg) begin
                if (rec_type_reg == T_NEXTPROT || rec_type_reg == T_AEAD) begin
                    if (hold_reg[8]) begin
                        hold_next = 9'd0;
                        if (rec_type_reg == T_NEXTPROT) begin
                            if (word == req_prot_reg)
                                seen_next[OFFER_PROT] = 1'b1;
                        end
                        else if (word == req_aead_reg) begin
                            seen_next[OFFER_AEAD] = 1'b1;
                        end
                    end
                    else begin
                        hold_next = {1'b1, b};
                    end
                end
                body_rem_next = rem_dec;
                if (rem_dec == '0) begin
                    in_body_next = 1'b0;
                    hold_next    = 9'd0;
                    if (pend_reg) begin
                        pend_next = 1'b0;
                        err_next  = 1'b1;
                        code_next = CODE_UNREC_CRIT;
                    end
                end
            end
            else begin
                unique case (hdr_idx_reg)
                    2'd0:
                    begin
                        crit_next     = b[7];
                        rec_type_next = {b[6:0], 8'd0};
                        hdr_idx_next  = 2'd1;
                    end
                    2'd1:
                    begin
                        rec_type_next = {rec_type_reg[TYPE_W-1:8], b};
                        hdr_idx_next  = 2'd2;
                    end
                    2'd2:
                    begin
                        body_rem_next = {b, 8'd0};
                        hdr_idx_next  = 2'd3;
                    end
                    default:
                    begin
                        // header complete: apply the rule of this record type
                        body_rem_next = len;
                        hdr_idx_next  = 2'd0;
                        unique case (rec_type_reg)
                            T_EOM:
                            begin
                                bad = !crit_reg || len != '0 || seen_reg[SEEN_END]
                                      || !s_axis_tlast;
                                if (!bad) seen_next[SEEN_END] = 1'b1;
                            end
                            T_NEXTPROT:
                            begin
                                bad = !crit_reg || seen_reg[SEEN_PROT] || len == '0 || len[0];
                                if (!bad) seen_next[SEEN_PROT] = 1'b1;
                            end
                            T_AEAD:
                            begin
                                bad = seen_reg[SEEN_AEAD] || len == '0 || len[0];
                                if (!bad) seen_next[SEEN_AEAD] = 1'b1;
                            end
                            T_ERROR, T_WARNING: bad = 1'b1;
                            T_SERVER: bad = (len == '0);
                            T_PORT:   bad = (len != 16'd2);
                            default:  pend_next = crit_reg;
                        endcase
                        if (bad) begin
                            err_next  = 1'b1;
                            code_next = CODE_BAD_REQ;
                        end
                        else begin
                            hold_next = 9'd0;
                            if (len != '0) begin
                                in_body_next = 1'b1;
                            end
                            else begin
                                in_body_next = 1'b0;
                                if (pend_next) begin
                                    // empty unknown critical body: flag at once
                                    pend_next = 1'b0;
                                    err_next  = 1'b1;
                                    code_next = CODE_UNREC_CRIT;
                                end
                            end
                        end
                    end
                endcase
            end
        end

        // verdict from the state after this byte
        verdict_acc  = 1'b0;
        verdict_code = CODE_BAD_REQ;
        if (err_next)
            verdict_code = code_next;
        else if (&seen_next) begin
            verdict_acc  = 1'b1;
            verdict_code = 1'b0;
        end

        out_valid_next = out_valid_reg && !m_fire;
        out_data_next  = out_data_reg;

        if (s_fire && s_axis_tlast) begin
            out_valid_next = 1'b1;
            out_data_next  = {verdict_code, verdict_acc};
            // re-arm for the next request
            hdr_idx_next  = 2'd0;
            in_body_next  = 1'b0;
            rec_type_next = '0;
            crit_next     = 1'b0;
            body_rem_next = '0;
            hold_next     = 9'd0;
            seen_next     = '0;
            pend_next     = 1'b0;
            err_next      = 1'b0;
            code_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_prot_reg  <= REQ_PROT_RESET;
            req_aead_reg  <= REQ_AEAD_RESET;
            hdr_idx_reg   <= 2'd0;
            in_body_reg   <= 1'b0;
            rec_type_reg  <= '0;
            crit_reg      <= 1'b0;
            body_rem_reg  <= '0;
            hold_reg      <= 9'd0;
            seen_reg      <= '0;
            pend_reg      <= 1'b0;
            err_reg       <= 1'b0;
            code_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_REQ_PROT)
                    req_prot_reg <= cfg_data;
                else if (cfg_index == REG_REQ_AEAD)
                    req_aead_reg <= cfg_data;
            end
            hdr_idx_reg   <= hdr_idx_next;
            in_body_reg   <= in_body_next;
            rec_type_reg  <= rec_type_next;
            crit_reg      <= crit_next;
            body_rem_reg  <= body_rem_next;
            hold_reg      <= hold_next;
            seen_reg      <= seen_next;
            pend_reg      <= pend_next;
            err_reg       <= err_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

`include "nts_ke_request_validator_assert.svh"

    `NKV_ASSERT_IMP(a_accept_no_code, out_valid_reg && out_data_reg[0], !out_data_reg[1])
    `NKV_ASSERT_NXT(a_last_gives_result, s_fire && s_axis_tlast, out_valid_reg)
    `NKV_ASSERT_NXT(a_last_rearms, s_fire && s_axis_tlast,
        hdr_idx_reg == 2'd0 && !in_body_reg && !err_reg && seen_reg == '0 && !pend_reg)
    `NKV_ASSERT_IMP(a_body_nonzero, in_body_reg, body_rem_reg != '0)
    `NKV_ASSERT_IMP(a_hold_in_list, hold_reg[8],
        in_body_reg && (rec_type_reg == T_NEXTPROT || rec_type_reg == T_AEAD))

endmodule

FILE: verif/nkv_verdict_checker.sv
// Watches the validator's channels, predicts each request verdict and compares it with the output.
module nkv_verdict_checker
    import nkv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
    input  logic                 s_axis_tlast,   // last_byte
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [7:0]           m_axis_tdata,   // [0] accepted, [1] reject_code, [7:2] zero
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ID_W-1:0]      cfg_data,
    output int unsigned          mismatches,
    output int unsigned          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic reject_code;
        logic accepted;
    } verdict_t;

    verdict_t verdict_q[$];
    verdict_t exp_v;
    int unsigned errs;

    // required identifiers
    logic [ID_W-1:0]   req_prot;
    logic [ID_W-1:0]   req_aead;

    // parser copy
    logic [2:0]        hdr_idx;
    logic              in_body;
    logic [TYPE_W-1:0] rtype;
    logic              crit;
    logic [LEN_W-1:0]  remaining;
    logic [8:0]        hold;       // bit 8: high byte of a list word is held
    logic [SEEN_W-1:0] seen;
    logic              pend_crit;
    logic              err_latched;
    logic              err_code;

    task automatic clear_parse();
        hdr_idx     = '0;
        in_body     = 1'b0;
        rtype       = '0;
        crit        = 1'b0;
        remaining   = '0;
        hold        = '0;
        seen        = '0;
        pend_crit   = 1'b0;
        err_latched = 1'b0;
        err_code    = 1'b0;
    endtask

    // first error wins
    task automatic note_error(input logic code);
        if (!err_latched) begin
            err_latched = 1'b1;
            err_code    = code;
        end
    endtask

    task automatic finish_body();
        in_body = 1'b0;
        hold    = '0;
        if (pend_crit) begin
            pend_crit = 1'b0;
            note_error(CODE_UNREC_CRIT);
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic l);
        logic [15:0]      word;
        logic [LEN_W-1:0] len;
        logic             bad;
        verdict_t         v;
        if (!err_latched) begin
            if (in_body) begin
                if (rtype == T_NEXTPROT || rtype == T_AEAD) begin
                    if (hold[8]) begin
                        word = {hold[7:0], b};
                        hold = '0;
                        if (rtype == T_NEXTPROT) begin
                            if (word == req_prot)
                                seen[OFFER_PROT] = 1'b1;
                        end else if (word == req_aead) begin
                            seen[OFFER_AEAD] = 1'b1;
                        end
                    end else begin
                        hold = {1'b1, b};
                    end
                end
                remaining = remaining - 1'b1;
                if (remaining == '0)
                    finish_body();
            end else begin
                case (hdr_idx)
                    3'd0:
                    begin
                        crit    = b[7];
                        rtype   = {b[6:0], 8'h00};
                        hdr_idx = 3'd1;
                    end
                    3'd1:
                    begin
                        rtype[7:0] = b;
                        hdr_idx    = 3'd2;
                    end
                    3'd2:
                    begin
                        remaining = {b, 8'h00};
                        hdr_idx   = 3'd3;
                    end
                    default:
                    begin
                        remaining[7:0] = b;
                        hdr_idx        = 3'd0;
                        len            = remaining;
                        bad            = 1'b0;
                        case (rtype)
                            T_EOM:
                                if (!crit || len != '0 || seen[SEEN_END] || !l)
                                    bad = 1'b1;
                                else
                                    seen[SEEN_END] = 1'b1;
                            T_NEXTPROT:
                                if (!crit || seen[SEEN_PROT] || len == '0 || len[0])
                                    bad = 1'b1;
                                else
                                    seen[SEEN_PROT] = 1'b1;
                            T_AEAD:
                                if (seen[SEEN_AEAD] || len == '0 || len[0])
                                    bad = 1'b1;
                                else
                                    seen[SEEN_AEAD] = 1'b1;
                            T_ERROR, T_WARNING:
                                bad = 1'b1;
                            T_SERVER:
                                bad = (len == '0);
                            T_PORT:
                                bad = (len != LEN_W'(2));
                            default:
                                pend_crit = crit;
                        endcase
                        if (bad) begin
                            note_error(CODE_BAD_REQ);
                        end else begin
                            hold = '0;
                            if (len != '0)
                                in_body = 1'b1;
                            else
                                finish_body();
                        end
                    end
                endcase
            end
        end
        if (l) begin
            v.accepted    = 1'b0;
            v.reject_code = CODE_BAD_REQ;
            if (err_latched) begin
                v.reject_code = err_code;
            end else if (&seen) begin
                v.accepted    = 1'b1;
                v.reject_code = 1'b0;    // code field is zero on accept
            end
            verdict_q.push_back(v);
            clear_parse();
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_prot = REQ_PROT_RESET;
            req_aead = REQ_AEAD_RESET;
            clear_parse();
            verdict_q.delete();
            errs = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            // output first: a verdict comes out only after its last byte has been taken
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: verdict with none outstanding, tdata=%02h",
                                 $time, m_axis_tdata);
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (m_axis_tdata[0] !== exp_v.accepted ||
                        m_axis_tdata[1] !== exp_v.reject_code ||
                        m_axis_tdata[7:2] !== '0) begin
                        errs++;
                        if (errs <= 10)
                            $display("%0t: verdict wrong: expected accepted=%0d code=%0d, got %02h",
                                     $time, exp_v.accepted, exp_v.reject_code, m_axis_tdata);
                    end
                end
            end
            // a byte taken at the same edge as a register write sees the old value
            if (s_axis_tvalid && s_axis_tready)
                predict_byte(s_axis_tdata, s_axis_tlast);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_REQ_PROT: req_prot = cfg_data;
                    REG_REQ_AEAD: req_aead = cfg_data;
                    default: ;
                endcase
            end
            mismatches  <= errs;
            outstanding <= verdict_q.size();
        end
    end

endmodule

FILE: verif/tb.sv
// Testbench top: request stimulus, configuration phases, idling, watchdog and verdict.
module tb
    import nkv_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS     = 1900;   // random bytes to send
    localparam int PHASES         = 6;      // configuration settings visited
    localparam int WATCHDOG_LIMIT = 2000;   // cycles without any transaction
    localparam int PRESSURE_AT    = 12;     // result count that starts the long hold-off
    localparam int PRESSURE_HOLD  = 300;

    typedef enum {
        REC_PROT, REC_AEAD, REC_SERVER, REC_PORT, REC_SKIP, REC_UCRIT, REC_RANDHDR
    } rec_kind_t;

    typedef enum {
        MUT_TRUNCATE, MUT_TRAILING, MUT_CORRUPT, MUT_NOISE
    } mutation_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // [7:0] data_byte
    logic                 s_axis_tlast;   // last_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;   // [0] accepted, [1] reject_code, [7:2] zero
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ID_W-1:0]      cfg_data;
    int unsigned          mismatches;
    int unsigned          outstanding;

    // bytes of the request being built, and the settings it is built for
    logic [7:0]      msg_q[$];
    logic [ID_W-1:0] cur_prot;
    logic [ID_W-1:0] cur_aead;
    int              sent_bytes;

    nts_ke_request_validator u_top (.*);

    nkv_verdict_checker u_checker (.*);

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Message building
    // ------------------------------------------------------------------

    // 4-byte record header: critical bit + 15-bit type, then 16-bit length
    task automatic put_header(input logic c, input logic [TYPE_W-1:0] t,
                              input logic [LEN_W-1:0] len);
        msg_q.push_back({c, t[14:8]});
        msg_q.push_back(t[7:0]);
        msg_q.push_back(len[15:8]);
        msg_q.push_back(len[7:0]);
    endtask

    task automatic put_word(input logic [15:0] w);
        msg_q.push_back(w[15:8]);
        msg_q.push_back(w[7:0]);
    endtask

    task automatic put_random_bytes(input int n);
        for (int i = 0; i < n; i++)
            msg_q.push_back(8'($urandom));
    endtask

    // Protocol or AEAD list; usually holds the required id once, and the
    // other words are random or near misses one bit away from it.
    task automatic put_list(input logic c, input logic [TYPE_W-1:0] t,
                            input logic [ID_W-1:0] req_id);
        int n;
        int hit;
        n   = $urandom_range(1, 4);
        hit = ($urandom_range(0, 4) != 0) ? int'($urandom_range(0, n - 1)) : -1;
        put_header(c, t, LEN_W'(2 * n));
        for (int i = 0; i < n; i++) begin
            if (i == hit)
                put_word(req_id);
            else if ($urandom_range(0, 2) == 0)
                put_word(req_id ^ (16'h0001 << $urandom_range(0, 15)));
            else
                put_word(16'($urandom));
        end
    endtask

    task automatic put_record(input rec_kind_t kind);
        int n;
        logic [TYPE_W-1:0] t;
        case (kind)
            REC_PROT:
                put_list($urandom_range(0, 19) != 0, T_NEXTPROT, cur_prot);
            REC_AEAD:
                put_list(1'($urandom), T_AEAD, cur_aead);
            REC_SERVER:
            begin
                n = $urandom_range(1, 6);
                put_header(1'($urandom), T_SERVER, LEN_W'(n));
                put_random_bytes(n);
            end
            REC_PORT:
            begin
                put_header(1'($urandom), T_PORT, LEN_W'(2));
                put_random_bytes(2);
            end
            REC_SKIP, REC_UCRIT:
            begin
                // unknown type, top of the range now and then
                t = ($urandom_range(0, 3) == 0) ? '1 : TYPE_W'($urandom_range(8, 32767));
                n = $urandom_range(0, 5);
                put_header(kind == REC_UCRIT, t, LEN_W'(n));
                put_random_bytes(n);
            end
            default:
            begin
                // any known type or the unknown types 5 and 8, short length
                n = $urandom_range(0, 3);
                put_header(1'($urandom), TYPE_W'($urandom_range(0, 8)), LEN_W'(n));
                put_random_bytes(n);
            end
        endcase
    endtask

    // Mostly well-formed requests with random content and order; about one
    // in four gets truncated, extended, corrupted or replaced by noise.
    task automatic build_request();
        rec_kind_t kinds[$];
        rec_kind_t tmp;
        int nx;
        int r;
        int j;
        int keep;
        kinds = {REC_PROT, REC_AEAD};
        nx = $urandom_range(0, 2);
        for (int i = 0; i < nx; i++) begin
            r = $urandom_range(0, 19);
            if (r < 5)
                kinds.push_back(REC_SERVER);
            else if (r < 10)
                kinds.push_back(REC_PORT);
            else if (r < 16)
                kinds.push_back(REC_SKIP);
            else if (r == 16)
                kinds.push_back(REC_UCRIT);
            else if (r == 17)
                kinds.push_back(REC_RANDHDR);
            else if (r == 18)
                kinds.push_back(REC_PROT);      // duplicate list
            else
                kinds.push_back(REC_AEAD);
        end
        if ($urandom_range(0, 24) == 0)
            kinds.delete($urandom_range(0, 1));  // one list missing
        for (int i = kinds.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = kinds[i];
            kinds[i] = kinds[j];
            kinds[j] = tmp;
        end
        msg_q.delete();
        foreach (kinds[i])
            put_record(kinds[i]);
        put_header(1'b1, T_EOM, '0);
        if ($urandom_range(0, 3) == 0) begin
            case (mutation_t'($urandom_range(0, 3)))
                MUT_TRUNCATE:
                begin
                    keep = $urandom_range(1, msg_q.size() - 1);
                    while (msg_q.size() > keep)
                        void'(msg_q.pop_back());
                end
                MUT_TRAILING:
                    put_random_bytes($urandom_range(1, 4));
                MUT_CORRUPT:
                    msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom);
                default:
                begin
                    msg_q.delete();
                    put_random_bytes($urandom_range(1, 12));
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // One byte transaction. tvalid stays high from byte to byte unless a gap
    // is drawn, so it never gets two assignments in one step.
    task automatic send_byte(input logic [7:0] d, input logic l, input bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= l;
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic send_request();
        bit calm;
        calm = ($urandom_range(0, 3) == 0);     // back-to-back burst
        foreach (msg_q[i])
            send_byte(msg_q[i], i == msg_q.size() - 1, calm);
        sent_bytes += msg_q.size();
    endtask

    // Does not lower cfg_valid, so back-to-back writes stay glitch free;
    // the caller lowers it after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
    endtask

    // Stop offering bytes and wait for every predicted verdict to come out.
    // The first edge lets the checker count the last byte's verdict.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall per result, calm stretches, one long hold-off
    // that backs the block up into its input.
    // ------------------------------------------------------------------
    initial begin
        int taken;
        int calm_left;
        int n;
        taken = 0;
        calm_left = 0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (taken == PRESSURE_AT) begin
                m_axis_tready <= 1'b0;
                repeat (PRESSURE_HOLD) @(posedge clk);
            end else begin
                if (calm_left > 0) begin
                    n = 0;
                    calm_left--;
                end else begin
                    if ($urandom_range(0, 9) == 0)
                        calm_left = 8;
                    n = $urandom_range(0, 6);
                end
                if (n > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
            taken++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any run of cycles with no transaction on any channel
    // longer than the limit means the block hung.
    // ------------------------------------------------------------------
    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [CFG_IDX_W-1:0] junk_idx;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        cur_prot   = REQ_PROT_RESET;
        cur_aead   = REQ_AEAD_RESET;
        sent_bytes = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under reset settings.
        // Smallest good request: both lists with the required ids, then end.
        msg_q.delete();
        put_header(1'b1, T_NEXTPROT, LEN_W'(2));
        put_word(REQ_PROT_RESET);
        put_header(1'b1, T_AEAD, LEN_W'(2));
        put_word(REQ_AEAD_RESET);
        put_header(1'b1, T_EOM, '0);
        send_request();
        // error record is always a bad request
        msg_q.delete();
        put_header(1'b1, T_ERROR, '0);
        send_request();
        // unknown critical, top type, body completes on the last byte
        msg_q.delete();
        put_header(1'b1, '1, LEN_W'(1));
        msg_q.push_back(8'hFF);
        send_request();
        // truncated inside a header
        msg_q = {8'h80};
        send_request();
        // trailing byte after end of message
        msg_q.delete();
        put_header(1'b1, T_EOM, '0);
        msg_q.push_back(8'h00);
        send_request();
        // largest body length, truncated right after the header
        msg_q.delete();
        put_header(1'b0, T_SERVER, '1);
        send_request();

        // Random requests over several register settings, extremes included.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain();
                case (phase)
                    1:
                    begin
                        cur_prot = '1;
                        cur_aead = '0;
                    end
                    2:
                    begin
                        cur_prot = '0;
                        cur_aead = '1;
                    end
                    PHASES - 1:
                    begin
                        cur_prot = REQ_PROT_RESET;
                        cur_aead = REQ_AEAD_RESET;
                    end
                    default:
                    begin
                        cur_prot = ID_W'($urandom);
                        cur_aead = ID_W'($urandom);
                    end
                endcase
                if (phase == 4) begin
                    // a write to an unused index must change nothing
                    junk_idx = CFG_IDX_W'($urandom_range(REG_REQ_AEAD + 1,
                                                         (1 << CFG_IDX_W) - 1));
                    write_reg(junk_idx, ID_W'($urandom));
                end
                write_reg(REG_REQ_PROT, cur_prot);
                write_reg(REG_REQ_AEAD, cur_aead);
                cfg_valid <= 1'b0;
            end
            while (sent_bytes < (phase + 1) * RAND_ITEMS / PHASES) begin
                build_request();
                send_request();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
